// ===== rtl/core/odo_pkg.sv =====
// Shared types, constants and the arctangent table of the odometry pose integrator.
// Used by odo_cordic and odometry_pose_integrator; depends on nothing else.
package odo_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] KIND_ENCODER = 2'd0;
    localparam logic [1:0] KIND_YAW     = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    // stream word layout
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 216;

    // register reset: 1.0 meter per count with 24 fraction bits
    localparam logic [31:0] MPT_RESET = 32'd16777216;

    // rotation CORDIC
    localparam int              CORDIC_STEPS = 28;
    localparam int              STEP_W       = 5;
    localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(CORDIC_STEPS - 1);
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032875;
    localparam logic signed [33:0] Q30_POS = 34'sd1073741824;
    localparam logic signed [33:0] Q30_NEG = -34'sd1073741824;

    // speed = m * 50 saturates when m exceeds floor(2^63 / 50)
    localparam logic [63:0] SPEED_SAT_THRESHOLD = 64'd184467440737095516;
    localparam logic [63:0] INT64_MAX_U = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN_U = 64'h8000_0000_0000_0000;

    // rounding half of a Q30 product
    localparam logic [63:0] Q30_HALF = 64'd536870912;

    // CORDIC result handed to the sequencer
    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_q30;
        logic signed [31:0] sin_q30;
    } t_trig;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turns(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            5'd24:   v = 32'h0000_0029;
            5'd25:   v = 32'h0000_0014;
            5'd26:   v = 32'h0000_000A;
            5'd27:   v = 32'h0000_0005;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/odometry_pose_integrator.sv =====
// Top level of the dead-reckoning pose integrator: sequencer, pose state, output register.
// Depends on odo_pkg, odo_mul (shared multiplier) and odo_cordic (heading cos/sin).
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser kind, tdata count/yaw/period
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata x, y, heading, speed, error
//  cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_data meters_per_tick
//
// Encoder, yaw, zero-period and spare-kind items run the speed states SPD_MUL, SPD_A,
// SPD_B and SPD_OUT, load their result into the output register and then free the input.
// A tick first runs TICK_START, which starts the distance multiply and the CORDIC; the
// CORDIC runs 28 micro-rotations plus a clamp and a done flag, and each axis then passes
// through MUL_LO, MUL_HI, ACC, SIGN and SAT: two passes through the shared 32x32
// multiplier, a round, a sign and a saturating add; the speed states then form speed.
// Synchronous active-low reset clears pose, heading, yaw history, count and error,
// and restores meters_per_tick to 1.0.
// One item is in work at a time; s_axis_tready is high only when idle. A finished
// result waits in the output register while the next word is taken.
module odometry_pose_integrator #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write: meters_per_tick
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [31:0]                      i_cfg_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] encoder_count, [47:32] yaw_angle, [67:48] period_time, [71:68] zero
    input  logic [odo_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]                       s_axis_tuser,
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [63:0] x_position, [127:64] y_position, [143:128] heading_angle,
    // [207:144] encoder_speed, [208] error_flag, [215:209] zero
    output logic [odo_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int EXT_W = ANGLE_BITS + 16;

    // sequencer codes
    localparam logic [3:0] ST_IDLE        = 4'd0;
    localparam logic [3:0] ST_TICK_START  = 4'd1;
    localparam logic [3:0] ST_DIST_LATCH  = 4'd2;
    localparam logic [3:0] ST_CORDIC_WAIT = 4'd3;
    localparam logic [3:0] ST_MUL_LO      = 4'd4;
    localparam logic [3:0] ST_MUL_HI      = 4'd5;
    localparam logic [3:0] ST_ACC         = 4'd6;
    localparam logic [3:0] ST_SIGN        = 4'd7;
    localparam logic [3:0] ST_SAT         = 4'd8;
    localparam logic [3:0] ST_SPD_MUL     = 4'd9;
    localparam logic [3:0] ST_SPD_A       = 4'd10;
    localparam logic [3:0] ST_SPD_B       = 4'd11;
    localparam logic [3:0] ST_SPD_OUT     = 4'd12;

    logic [3:0]                     r_state;
    logic [3:0]                     n_state;
    logic [31:0]                    r_mpt;
    logic signed [63:0]             r_pos_x;
    logic signed [63:0]             r_pos_y;
    logic [ANGLE_BITS-1:0]          r_heading;
    logic signed [31:0]             r_count;
    logic [ANGLE_BITS-1:0]          r_latest_yaw;
    logic [ANGLE_BITS-1:0]          r_prev_yaw;
    logic                           r_err;
    logic [61:0]                    r_dist;
    logic signed [31:0]             r_cos;
    logic signed [31:0]             r_sin;
    logic                           r_axis;
    logic [63:0]                    r_acc;
    logic                           r_over;
    logic                           r_out_valid;
    logic [odo_pkg::OUT_DATA_W-1:0] r_out_data;

    logic                  in_fire;
    logic                  cfg_fire;
    logic [1:0]            in_kind;
    logic signed [31:0]    in_count;
    logic [15:0]           in_yaw;
    logic [19:0]           in_period;
    logic [EXT_W-1:0]      yaw_ext;
    logic [EXT_W-1:0]      hdg_ext;

    logic signed [31:0]    half_sum;
    logic signed [31:0]    half;
    logic [31:0]           abs_half;
    logic [31:0]           abs_count;
    logic signed [31:0]    f_sel;
    logic [31:0]           abs_f;
    logic                  term_neg;
    logic signed [63:0]    cur_pos;
    logic signed [63:0]    term;
    logic signed [63:0]    sum;
    logic signed [63:0]    sat_sum;
    logic [63:0]           spd_mag;
    logic [63:0]           spd_val;
    logic                  out_load;

    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [63:0]           prod;
    logic                  cordic_start;
    odo_pkg::t_trig        trig;

    // ---------------------------------------------------------------
    // Field unpacking and handshakes
    // ---------------------------------------------------------------
    assign in_kind   = s_axis_tuser;
    assign in_count  = $signed(s_axis_tdata[31:0]);
    assign in_yaw    = s_axis_tdata[47:32];
    assign in_period = s_axis_tdata[67:48];
    assign yaw_ext   = EXT_W'(in_yaw);
    assign hdg_ext   = EXT_W'(r_heading);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_fire      = i_cfg_valid && o_cfg_ready;

    // ---------------------------------------------------------------
    // Operand preparation
    // ---------------------------------------------------------------
    always_comb begin
        // trunc(count / 2): bias negatives by one before the arithmetic shift
        half_sum  = r_count + $signed({31'b0, r_count[31]});
        half      = half_sum >>> 1;
        abs_half  = half[31] ? 32'(-half) : 32'(half);
        // most negative count maps to 2^31, still fits unsigned
        abs_count = r_count[31] ? 32'(-r_count) : 32'(r_count);
        f_sel     = r_axis ? r_sin : r_cos;
        abs_f     = f_sel[31] ? 32'(-f_sel) : 32'(f_sel);
        term_neg  = half[31] ^ f_sel[31];
        cur_pos   = r_axis ? r_pos_y : r_pos_x;
        term      = $signed(r_acc);
        sum       = cur_pos + term;
        // overflow only when both addends share a sign the sum lost
        if ((cur_pos[63] == term[63]) && (sum[63] != cur_pos[63])) begin
            sat_sum = cur_pos[63] ? $signed(odo_pkg::INT64_MIN_U)
                                  : $signed(odo_pkg::INT64_MAX_U);
        end else begin
            sat_sum = sum;
        end
        if (r_over) begin
            spd_mag = r_count[31] ? odo_pkg::INT64_MIN_U : odo_pkg::INT64_MAX_U;
        end else begin
            spd_mag = r_acc;
        end
        spd_val  = r_count[31] ? (64'd0 - spd_mag) : spd_mag;
        out_load = (r_state == ST_SPD_OUT) && (!r_out_valid || m_axis_tready);
    end

    // shared multiplier operands; speed operands by default so the product holds
    always_comb begin
        case (r_state)
            ST_TICK_START: begin
                mul_a = abs_half;
                mul_b = r_mpt;
            end
            ST_MUL_LO: begin
                mul_a = r_dist[31:0];
                mul_b = abs_f;
            end
            ST_MUL_HI: begin
                mul_a = {2'b00, r_dist[61:32]};
                mul_b = abs_f;
            end
            default: begin
                mul_a = abs_count;
                mul_b = r_mpt;
            end
        endcase
    end

    assign cordic_start = (r_state == ST_TICK_START);

    odo_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    odo_cordic #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (r_heading),
        .o_trig  (trig)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if ((in_kind == odo_pkg::KIND_TICK) && (in_period != '0)) begin
                        n_state = ST_TICK_START;
                    end else begin
                        n_state = ST_SPD_MUL;
                    end
                end
            end
            ST_TICK_START:  n_state = ST_DIST_LATCH;
            ST_DIST_LATCH:  n_state = ST_CORDIC_WAIT;
            ST_CORDIC_WAIT: begin
                if (trig.done) begin
                    n_state = ST_MUL_LO;
                end
            end
            ST_MUL_LO:      n_state = ST_MUL_HI;
            ST_MUL_HI:      n_state = ST_ACC;
            ST_ACC:         n_state = ST_SIGN;
            ST_SIGN:        n_state = ST_SAT;
            ST_SAT:         n_state = r_axis ? ST_SPD_MUL : ST_MUL_LO;
            ST_SPD_MUL:     n_state = ST_SPD_A;
            ST_SPD_A:       n_state = ST_SPD_B;
            ST_SPD_B:       n_state = ST_SPD_OUT;
            ST_SPD_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:        n_state = ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mpt        <= odo_pkg::MPT_RESET;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_heading    <= '0;
            r_count      <= '0;
            r_latest_yaw <= '0;
            r_prev_yaw   <= '0;
            r_err        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_fire) begin
                r_mpt <= i_cfg_data;
            end
            if (in_fire) begin
                case (in_kind)
                    odo_pkg::KIND_ENCODER: r_count      <= in_count;
                    odo_pkg::KIND_YAW:     r_latest_yaw <= yaw_ext[ANGLE_BITS-1:0];
                    odo_pkg::KIND_TICK: begin
                        if (in_period == '0) begin
                            r_err <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == ST_SAT) begin
                if (r_axis) begin
                    r_pos_y <= sat_sum;
                    // heading advances after both axes used the old one
                    r_heading  <= r_heading + r_latest_yaw - r_prev_yaw;
                    r_prev_yaw <= r_latest_yaw;
                end else begin
                    r_pos_x <= sat_sum;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_DIST_LATCH: r_dist <= prod[61:0];
            ST_CORDIC_WAIT: begin
                r_cos  <= trig.cos_q30;
                r_sin  <= trig.sin_q30;
                r_axis <= 1'b0;
            end
            // low partial product, rounded at the Q30 point
            ST_MUL_HI:     r_acc <= (prod + odo_pkg::Q30_HALF) >> 30;
            // high partial product weighs 2^32 / 2^30
            ST_ACC:        r_acc <= r_acc + (prod << 2);
            ST_SIGN:       r_acc <= term_neg ? (64'd0 - r_acc) : r_acc;
            ST_SAT:        r_axis <= 1'b1;
            // speed: m * 50 as m*32 + m*16 + m*2
            ST_SPD_A: begin
                r_over <= (prod > odo_pkg::SPEED_SAT_THRESHOLD);
                r_acc  <= (prod << 5) + (prod << 4);
            end
            ST_SPD_B:      r_acc <= r_acc + (prod << 1);
            default: ;
        endcase
        if (out_load) begin
            r_out_data <= {7'b0, r_err, spd_val, hdg_ext[15:0], r_pos_y, r_pos_x};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("error flag cleared without reset");

    a_heading_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SAT) |=> $stable(r_heading))
        else $error("heading moved outside the pose update");

    a_cordic_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trig.done |-> (r_state == ST_CORDIC_WAIT))
        else $error("CORDIC finished while the sequencer was not waiting");

endmodule

// ===== rtl/core/odo_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing; used by odometry_pose_integrator.
module odo_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/odo_cordic.sv =====
// Iterative rotation CORDIC: one micro-rotation per cycle, cos and sin in Q30.
// Depends on odo_pkg (step count, gain, atan table, t_trig).
module odo_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output odo_pkg::t_trig        o_trig
);

    logic                          r_busy;
    logic                          r_fin;
    logic                          r_done;
    logic                          r_flip;
    logic [odo_pkg::STEP_W-1:0]    r_step;
    logic signed [33:0]            r_x;
    logic signed [33:0]            r_y;
    logic signed [32:0]            r_z;
    logic signed [31:0]            r_cos;
    logic signed [31:0]            r_sin;

    logic [31:0]        a_wide;
    logic               flip;
    logic [31:0]        a_fold;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [32:0] dz;
    logic signed [33:0] xf;
    logic signed [33:0] yf;

    function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
        logic signed [33:0] c;
        if (v > odo_pkg::Q30_POS) begin
            c = odo_pkg::Q30_POS;
        end else if (v < odo_pkg::Q30_NEG) begin
            c = odo_pkg::Q30_NEG;
        end else begin
            c = v;
        end
        return c[31:0];
    endfunction

    // widen to 2^-32 turn and fold into the right half plane
    always_comb begin
        a_wide = 32'(i_angle) << (32 - ANGLE_BITS);
        flip   = a_wide[31] ^ a_wide[30];
        a_fold = {a_wide[31] ^ flip, a_wide[30:0]};
    end

    always_comb begin
        dx = r_y >>> r_step;
        dy = r_x >>> r_step;
        dz = $signed({1'b0, odo_pkg::atan_turns(r_step)});
        xf = r_flip ? -r_x : r_x;
        yf = r_flip ? -r_y : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
            end else if (r_busy) begin
                if (r_step == odo_pkg::LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= odo_pkg::CORDIC_GAIN_Q30;
            r_y    <= '0;
            r_z    <= $signed({a_fold[31], a_fold});
            r_flip <= flip;
            r_step <= '0;
        end else if (r_busy) begin
            if (!r_z[32]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - dz;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + dz;
            end
            r_step <= r_step + 1'b1;
        end
        if (r_fin) begin
            r_cos <= clamp_q30(xf);
            r_sin <= clamp_q30(yf);
        end
    end

    assign o_trig.done    = r_done;
    assign o_trig.cos_q30 = r_cos;
    assign o_trig.sin_q30 = r_sin;

endmodule
